// ----- design/psp_pkg.sv -----
package psp_pkg;

    localparam int JOINTS_DEF = 8;
    localparam int FRAMES_DEF = 4096;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_RAMP   = 2'd1,
        PH_PLAY   = 2'd2,
        PH_FINISH = 2'd3
    } t_phase;

    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_RAMP_TICKS  = 2'd1;
    localparam logic [1:0] CFG_THRESH      = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         joint_index;
        logic [11:0]        frame_index;
        logic signed [31:0] value;
        logic               last_joint;
    } t_in;

    typedef struct packed {
        logic [5:0]         out_joint;
        logic signed [31:0] position;
        logic [1:0]         phase;
        logic               no_trajectory;
        logic               last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRD,
        S_DACC,
        S_DEC,
        S_ERD,
        S_EDIV,
        S_EWAIT,
        S_EOUT
    } t_state;

endpackage

// ----- design/pose_sequence_player.sv -----
// Write, start and non-final tick beats are handled in the idle state, which stays ready.
// A final tick beat runs a distance pass over the joints (ramping only), then per joint reads the
// memories and emits a result (after the serial divider while ramping), plus output stalls.
// Throughput: one beat at a time; the divider and the single-port memories limit it.
// Reset: synchronous, active low; phase waiting, counters zero, registers at defaults.
// Trajectory and posture memories are not cleared.
module pose_sequence_player #(
    parameter int JOINTS = psp_pkg::JOINTS_DEF,
    parameter int FRAMES = psp_pkg::FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  psp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output psp_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int TAW = FW + JW;
    localparam int TD  = FRAMES * (2 ** JW);

    // configuration
    logic [12:0] r_frame_count;
    logic [15:0] r_ramp_ticks;
    logic [31:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_ramp_ticks  <= 16'd3000;
            r_thresh      <= 32'd43;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psp_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[12:0];
                psp_pkg::CFG_RAMP_TICKS:  r_ramp_ticks  <= i_cfg_data[15:0];
                psp_pkg::CFG_THRESH:      r_thresh      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frames in use
    logic [16:0] w_n;
    assign w_n = ({4'd0, r_frame_count} > 17'(FRAMES)) ? 17'(FRAMES) : {4'd0, r_frame_count};

    // control state
    psp_pkg::t_state r_st, n_st;
    psp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_ramp_count, n_ramp_count;
    logic [11:0] r_play_index, n_play_index;
    logic [FW-1:0] r_src, n_src;
    logic [JW:0] r_j, n_j;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_sq, n_sq;
    logic r_mode_meas, n_mode_meas;  // output measured posture
    logic r_mode_div, n_mode_div;    // ramp step
    logic r_notraj, n_notraj;
    logic signed [31:0] r_meas, n_meas;
    logic signed [31:0] r_pos, n_pos;
    logic r_ovalid, n_ovalid;

    // memories
    logic          w_twe, w_mwe;
    logic [TAW-1:0] w_taddr;
    logic [JW-1:0]  w_maddr;
    logic [31:0]    w_trd, w_mrd;

    psp_mem #(.DEPTH(TD), .AW(TAW)) u_traj (
        .i_clk(i_clk), .i_we(w_twe), .i_addr(w_taddr),
        .i_wdata(i_data.value), .o_rdata(w_trd)
    );
    psp_mem #(.DEPTH(2 ** JW), .AW(JW)) u_meas (
        .i_clk(i_clk), .i_we(w_mwe), .i_addr(w_maddr),
        .i_wdata(i_data.value), .o_rdata(w_mrd)
    );

    // divider; ramp count is already stepped when the division starts
    logic w_div_start, w_div_busy;
    logic signed [33:0] w_quo, w_diff;
    logic [16:0] w_den;
    assign w_diff = 34'(signed'(w_trd)) - 34'(signed'(r_meas));
    assign w_den  = {1'b0, r_ramp_ticks} - {1'b0, r_ramp_count} + 17'd1;

    psp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_diff), .i_den(w_den), .o_busy(w_div_busy), .o_quo(w_quo)
    );

    logic w_acc_in;
    logic [32:0] w_abs;
    logic signed [32:0] w_d33;
    logic [64:0] w_sum;
    logic w_jok;
    assign w_acc_in = o_ready && i_valid;
    assign w_jok    = {1'b0, i_data.joint_index} < 7'(JOINTS);
    assign w_d33    = 33'(signed'(w_trd)) - 33'(signed'(w_mrd));
    assign w_abs    = w_d33[32] ? 33'(-w_d33) : w_d33;
    assign w_sum    = {1'b0, r_acc} + {1'b0, r_sq};

    always_comb begin
        n_st = r_st; n_phase = r_phase; n_ramp_count = r_ramp_count;
        n_play_index = r_play_index; n_src = r_src; n_j = r_j; n_acc = r_acc;
        n_sq = r_sq; n_mode_meas = r_mode_meas; n_mode_div = r_mode_div;
        n_notraj = r_notraj; n_meas = r_meas; n_pos = r_pos; n_ovalid = r_ovalid;
        o_ready = 1'b0; w_twe = 1'b0; w_mwe = 1'b0; w_div_start = 1'b0;
        w_taddr = {r_src, r_j[JW-1:0]};
        w_maddr = r_j[JW-1:0];
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_st)
            psp_pkg::S_IDLE: begin
                o_ready = 1'b1;
                w_taddr = {i_data.frame_index[FW-1:0], i_data.joint_index[JW-1:0]};
                w_maddr = i_data.joint_index[JW-1:0];
                if (w_acc_in) begin
                    unique case (i_data.opcode)
                        psp_pkg::OP_WRITE: begin
                            n_phase = psp_pkg::PH_WAIT;
                            w_twe = w_jok && ({5'd0, i_data.frame_index} < 17'(FRAMES));
                        end
                        psp_pkg::OP_START: begin
                            if (r_phase == psp_pkg::PH_WAIT) begin
                                n_phase = psp_pkg::PH_RAMP;
                                n_ramp_count = '0;
                                n_play_index = '0;
                            end
                        end
                        psp_pkg::OP_TICK: begin
                            w_mwe = w_jok;
                            if (i_data.last_joint) begin
                                n_j = '0;
                                n_acc = '0;
                                n_sq = '0;
                                n_src = '0;
                                n_mode_div = 1'b0;
                                n_notraj = 1'b0;
                                if (r_phase == psp_pkg::PH_WAIT || w_n == 17'd0) begin
                                    n_mode_meas = 1'b1;
                                    n_notraj = (r_phase != psp_pkg::PH_WAIT);
                                    n_st = psp_pkg::S_ERD;
                                end else if (r_phase == psp_pkg::PH_RAMP) begin
                                    n_mode_meas = 1'b0;
                                    n_st = psp_pkg::S_DRD;
                                end else begin
                                    n_mode_meas = 1'b0;
                                    if (r_phase == psp_pkg::PH_PLAY) begin
                                        if ({5'd0, r_play_index} >= w_n - 17'd1) begin
                                            n_src = FW'(w_n - 17'd1);
                                            n_phase = psp_pkg::PH_FINISH;
                                        end else begin
                                            n_src = r_play_index[FW-1:0];
                                            n_play_index = r_play_index + 12'd1;
                                        end
                                    end else begin
                                        n_src = FW'(w_n - 17'd1);
                                    end
                                    n_st = psp_pkg::S_ERD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            psp_pkg::S_DRD: n_st = psp_pkg::S_DACC;  // reads issued at {0,j}
            psp_pkg::S_DACC: begin
                n_acc = w_sum[64] ? '1 : w_sum[63:0];
                n_sq = {31'd0, w_abs} * {31'd0, w_abs};
                if (r_j == (JW+1)'(JOINTS - 1)) begin
                    n_st = psp_pkg::S_DEC;
                end else begin
                    n_j = r_j + 1'b1;
                    n_st = psp_pkg::S_DRD;
                end
            end
            psp_pkg::S_DEC: begin
                n_j = '0;
                n_acc = w_sum[64] ? '1 : w_sum[63:0];
                if (w_sum[64] == 1'b0 && w_sum[63:0] < {32'd0, r_thresh}
                    || r_ramp_count >= r_ramp_ticks) begin
                    n_phase = psp_pkg::PH_PLAY;
                    n_play_index = 12'd1;
                end else begin
                    n_mode_div = 1'b1;
                    n_ramp_count = r_ramp_count + 16'd1;
                end
                n_st = psp_pkg::S_ERD;
            end
            psp_pkg::S_ERD: n_st = psp_pkg::S_EDIV;
            psp_pkg::S_EDIV: begin
                n_meas = w_mrd;
                if (r_mode_meas) begin
                    n_pos = w_mrd;
                    n_st = psp_pkg::S_EOUT;
                end else if (r_mode_div) begin
                    n_st = psp_pkg::S_EWAIT;
                end else begin
                    n_pos = w_trd;
                    n_st = psp_pkg::S_EOUT;
                end
            end
            psp_pkg::S_EWAIT: begin
                // w_trd still holds frame 0 data: address held
                if (!w_div_busy && !r_ovalid) begin
                    w_div_start = 1'b1;
                end
                if (w_div_start) begin
                    n_st = psp_pkg::S_EOUT;
                end
            end
            psp_pkg::S_EOUT: begin
                if (!w_div_busy && (!r_ovalid || i_ready)) begin
                    if (r_mode_div) begin
                        n_pos = r_meas + w_quo[31:0];
                    end
                    n_ovalid = 1'b1;
                    if (r_j == (JW+1)'(JOINTS - 1)) begin
                        n_st = psp_pkg::S_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_st = psp_pkg::S_ERD;
                    end
                end
            end
            default: n_st = psp_pkg::S_IDLE;
        endcase
    end

    // output register, loaded only when the previous beat has gone
    logic [JW:0]        r_oj;
    logic signed [31:0] r_opos;
    psp_pkg::t_phase    r_ophase;
    logic               r_onotraj;
    logic               w_oload;
    assign w_oload = n_ovalid && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= psp_pkg::S_IDLE;
            r_phase <= psp_pkg::PH_WAIT;
            r_ramp_count <= '0;
            r_play_index <= '0;
            r_ovalid <= 1'b0;
            r_j <= '0;
            r_acc <= '0;
        end else begin
            r_st <= n_st;
            r_phase <= n_phase;
            r_ramp_count <= n_ramp_count;
            r_play_index <= n_play_index;
            r_ovalid <= n_ovalid;
            r_j <= n_j;
            r_acc <= n_acc;
        end
        r_src <= n_src; r_sq <= n_sq; r_mode_meas <= n_mode_meas;
        r_mode_div <= n_mode_div; r_notraj <= n_notraj; r_meas <= n_meas;
        r_pos <= n_pos;
        if (w_oload) begin
            r_oj      <= r_j;
            r_opos    <= n_pos;
            r_ophase  <= r_phase;
            r_onotraj <= r_notraj;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data.out_joint = 6'(r_oj);
    assign o_data.position = r_opos;
    assign o_data.phase = r_ophase;
    assign o_data.no_trajectory = r_onotraj;
    assign o_data.last = (r_oj == (JW+1)'(JOINTS - 1));
endmodule

// ----- design/psp_div.sv -----
// Signed 34-bit by unsigned 17-bit division, truncating toward zero; one quotient bit a cycle.
module psp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_num,
    input  logic        [16:0] i_den,
    output logic               o_busy,
    output logic signed [33:0] o_quo
);
    logic [33:0] r_q;
    logic [33:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic [34:0] w_trial;
    logic [33:0] w_rem_sh;

    assign w_rem_sh = {r_rem[32:0], r_q[33]};
    assign w_trial  = {1'b0, w_rem_sh} - {18'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd34;
            r_neg  <= i_num[33];
            r_q    <= i_num[33] ? 34'(-i_num) : i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_trial[34]) begin
                r_rem <= w_trial[33:0];
                r_q   <= {r_q[32:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q   <= {r_q[32:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? 34'(-r_q) : r_q;
endmodule

// ----- design/psp_mem.sv -----
// Single-port RAM, registered read.
module psp_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- dv/psp_checker.sv -----
`timescale 1ns / 1ps

module psp_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  psp_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  psp_pkg::t_out i_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending
);

    localparam int NJ = psp_pkg::JOINTS_DEF;
    localparam int NF = psp_pkg::FRAMES_DEF;

    // shadow of the block: registers, phase, counters, memories
    logic [12:0]     frames_cfg;
    logic [15:0]     ramp_budget;
    logic [31:0]     close_sq;
    psp_pkg::t_phase cur_phase;
    logic [15:0]     ramp_cnt;
    logic [11:0]     play_idx;
    logic [31:0]     traj_mem [0:NF*NJ-1];
    logic [31:0]     posture [0:NJ-1];

    psp_pkg::t_out ref_q [$];
    int            err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = ref_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // one accepted input beat; a final tick beat queues one result per joint
    task automatic step_beat(input psp_pkg::t_in b);
        longint        pos [0:NJ-1];
        longint        d;
        longint        den;
        logic [63:0]   mag;
        logic [64:0]   sum;
        logic [63:0]   dist_sq;
        int            n;
        int            src;
        logic          no_traj;
        psp_pkg::t_out r;
        no_traj = 1'b0;
        case (psp_pkg::t_opcode'(b.opcode))
            psp_pkg::OP_WRITE: begin
                cur_phase = psp_pkg::PH_WAIT;
                if (b.joint_index < NJ)
                    traj_mem[b.frame_index * NJ + b.joint_index] = b.value;
            end
            psp_pkg::OP_START: begin
                if (cur_phase == psp_pkg::PH_WAIT) begin
                    cur_phase = psp_pkg::PH_RAMP;
                    ramp_cnt  = '0;
                    play_idx  = '0;
                end
            end
            psp_pkg::OP_TICK: begin
                if (b.joint_index < NJ)
                    posture[b.joint_index] = b.value;
                if (b.last_joint) begin
                    n = (frames_cfg > NF) ? NF : int'(frames_cfg);
                    if (cur_phase == psp_pkg::PH_WAIT || n == 0) begin
                        no_traj = (cur_phase != psp_pkg::PH_WAIT);
                        for (int j = 0; j < NJ; j++) pos[j] = sx(posture[j]);
                    end else if (cur_phase == psp_pkg::PH_RAMP) begin
                        dist_sq = '0;
                        for (int j = 0; j < NJ; j++) begin
                            d       = sx(traj_mem[j]) - sx(posture[j]);
                            mag     = (d < 0) ? -d : d;
                            sum     = {1'b0, dist_sq} + {1'b0, mag * mag};
                            dist_sq = sum[64] ? '1 : sum[63:0];
                        end
                        if (dist_sq < {32'd0, close_sq} || ramp_cnt >= ramp_budget) begin
                            cur_phase = psp_pkg::PH_PLAY;
                            play_idx  = 12'd1;
                            for (int j = 0; j < NJ; j++) pos[j] = sx(traj_mem[j]);
                        end else begin
                            den = longint'(ramp_budget) - longint'(ramp_cnt);
                            for (int j = 0; j < NJ; j++) begin
                                d      = sx(traj_mem[j]) - sx(posture[j]);
                                pos[j] = sx(posture[j]) + d / den;
                            end
                            ramp_cnt = ramp_cnt + 16'd1;
                        end
                    end else begin
                        if (cur_phase == psp_pkg::PH_PLAY) begin
                            src = play_idx;
                            if (src >= n - 1) begin
                                src       = n - 1;
                                cur_phase = psp_pkg::PH_FINISH;
                            end else begin
                                play_idx = 12'(src + 1);
                            end
                        end else begin
                            src = n - 1;
                        end
                        for (int j = 0; j < NJ; j++) pos[j] = sx(traj_mem[src * NJ + j]);
                    end
                    for (int j = 0; j < NJ; j++) begin
                        r.out_joint     = 6'(j);
                        r.position      = pos[j][31:0];
                        r.phase         = cur_phase;
                        r.no_trajectory = no_traj;
                        r.last          = (j == NJ - 1);
                        ref_q           = {ref_q, r};
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        psp_pkg::t_out want;
        if (!i_rst_n) begin
            frames_cfg  = '0;
            ramp_budget = 16'd3000;
            close_sq    = 32'd43;
            cur_phase   = psp_pkg::PH_WAIT;
            ramp_cnt    = '0;
            play_idx    = '0;
            ref_q.delete();
            err_cnt     = 0;
        end else begin
            // results first: they never stem from the beat accepted at this edge
            if (i_out_valid && i_out_ready) begin
                if (ref_q.size() == 0) begin
                    report("unexpected beat, joint", 32'(i_out_data.out_joint), 32'd0);
                end else begin
                    want = ref_q.pop_front();
                    if (i_out_data.out_joint != want.out_joint)
                        report("out_joint", 32'(i_out_data.out_joint), 32'(want.out_joint));
                    if (i_out_data.position != want.position)
                        report("position", i_out_data.position, want.position);
                    if (i_out_data.phase != want.phase)
                        report("phase", 32'(i_out_data.phase), 32'(want.phase));
                    if (i_out_data.no_trajectory != want.no_trajectory)
                        report("no_trajectory", 32'(i_out_data.no_trajectory),
                               32'(want.no_trajectory));
                    if (i_out_data.last != want.last)
                        report("last", 32'(i_out_data.last), 32'(want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                step_beat(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psp_pkg::CFG_FRAME_COUNT: frames_cfg  = i_cfg_data[12:0];
                    psp_pkg::CFG_RAMP_TICKS:  ramp_budget = i_cfg_data[15:0];
                    psp_pkg::CFG_THRESH:      close_sq    = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int NJ         = psp_pkg::JOINTS_DEF;
    localparam int LOADED     = 8;      // frames 0..LOADED-1 hold known data
    localparam int ITEM_GOAL  = 360;
    localparam int IDLE_LIMIT = 20000;  // cycles with no beat and no register write
    localparam int SETTLE     = 400;    // worst final-tick latency, rounded up

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    psp_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    psp_pkg::t_out o_data;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [31:0]   i_cfg_data;

    int errors;
    int pending;
    int items_sent;
    int idle_cycles;
    bit rx_eager;       // receiver takes every beat without stalling
    bit tx_eager;       // sender offers back to back
    bit rx_long_hold;   // one long receiver stall, cleared by the receiver

    logic [31:0] frame0 [0:NJ-1];   // what frame 0 holds, to aim ticks near it

    pose_sequence_player dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    psp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_ready (o_ready),
        .i_in_data  (i_data),
        .i_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_out_data (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog: no beat on either side and no register write for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, eager stretches, one long hold-off
    initial begin
        int  k;
        bit  took;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end
            k = rx_eager ? 0 : $urandom_range(0, 3);
            if (k > 0) begin
                i_ready <= 1'b0;
                repeat (k) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = o_valid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // offer one beat; returns at the edge that accepts it
    task automatic send(input psp_pkg::t_opcode op, input int jnt, input int frm,
                        input logic [31:0] val, input bit lastj);
        int gap;
        bit rdy;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid                <= 1'b1;
        i_data.opcode          <= op;
        i_data.joint_index     <= jnt[5:0];
        i_data.frame_index     <= frm[11:0];
        i_data.value           <= val;
        i_data.last_joint      <= lastj;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
        items_sent++;
    endtask

    task automatic write_traj(input int frm, input int jnt, input logic [31:0] val);
        if (frm == 0 && jnt < NJ) frame0[jnt] = val;
        send(psp_pkg::OP_WRITE, jnt, frm, val, 1'b0);
    endtask

    // a full posture, joints in order; near frame 0 at times so the ramp can close
    task automatic full_tick(input bit near);
        logic [31:0] v;
        for (int j = 0; j < NJ; j++) begin
            v = near ? frame0[j] + $urandom_range(0, 6) - 3 : $urandom;
            send(psp_pkg::OP_TICK, j, $urandom, v, j == NJ - 1);
        end
    endtask

    // stray beats: unused opcode, ticks and writes to bad joints (a write still returns to waiting), starts
    task automatic noise();
        case ($urandom_range(0, 3))
            0: send(psp_pkg::OP_NONE, $urandom, $urandom, $urandom, 1'($urandom));
            1: send(psp_pkg::OP_TICK, $urandom_range(NJ, 63), $urandom, $urandom, 1'b0);
            2: send(psp_pkg::OP_WRITE, $urandom_range(NJ, 63), $urandom, $urandom, 1'b0);
            default: send(psp_pkg::OP_START, $urandom, $urandom, $urandom, 1'b0);
        endcase
    endtask

    // registers change only with nothing in flight and nothing being computed
    task automatic set_regs(input logic [12:0] fc, input logic [15:0] rt,
                            input logic [31:0] thr);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= psp_pkg::CFG_FRAME_COUNT;
        i_cfg_data  <= {19'd0, fc};
        @(posedge i_clk);
        i_cfg_index <= psp_pkg::CFG_RAMP_TICKS;
        i_cfg_data  <= {16'd0, rt};
        @(posedge i_clk);
        i_cfg_index <= psp_pkg::CFG_THRESH;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [31:0] thr;
        int          nticks;
        int          phase_no;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data       <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= psp_pkg::CFG_FRAME_COUNT;
        i_cfg_data   <= '0;
        items_sent   = 0;
        rx_eager     = 1'b0;
        tx_eager     = 1'b0;
        rx_long_hold = 1'b0;
        for (int j = 0; j < NJ; j++) frame0[j] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // waiting passes the posture through; extremes of the value field
        send(psp_pkg::OP_TICK, 0, 12'hFFF, 32'h7FFF_FFFF, 1'b0);
        send(psp_pkg::OP_TICK, 1, 0, 32'h8000_0000, 1'b0);
        send(psp_pkg::OP_TICK, 2, 0, 32'h0000_0000, 1'b0);
        send(psp_pkg::OP_TICK, 3, 0, 32'hFFFF_FFFF, 1'b0);
        send(psp_pkg::OP_TICK, 4, 0, 32'h0001_0000, 1'b0);
        send(psp_pkg::OP_TICK, 5, 0, 32'hFFFF_0000, 1'b0);
        send(psp_pkg::OP_TICK, 6, 0, 32'h5555_5555, 1'b0);
        send(psp_pkg::OP_TICK, 7, 0, 32'hAAAA_AAAA, 1'b1);
        send(psp_pkg::OP_NONE, 63, 12'hFFF, 32'hFFFF_FFFF, 1'b1);  // unused opcode
        send(psp_pkg::OP_TICK, 63, 12'hFFF, 32'h1234_5678, 1'b1);  // bad joint, still emits
        send(psp_pkg::OP_WRITE, 63, 0, 32'hDEAD_BEEF, 1'b0);       // bad joint, dropped
        send(psp_pkg::OP_WRITE, 7, 12'hFFF, 32'hCAFE_F00D, 1'b0);  // top frame
        // start with a zero frame count: measured held, no_trajectory set
        send(psp_pkg::OP_START, 0, 0, 0, 1'b0);
        send(psp_pkg::OP_START, 0, 0, 0, 1'b0);                    // not waiting: ignored
        send(psp_pkg::OP_TICK, 7, 0, 32'h0000_0007, 1'b1);
        send(psp_pkg::OP_WRITE, 0, 0, 32'h0, 1'b0);                // back to waiting

        // known trajectory in the low frames
        tx_eager = 1'b1;
        for (int f = 0; f < LOADED; f++)
            for (int j = 0; j < NJ; j++)
                write_traj(f, j, (f == 0 && j == 0) ? 32'h7FFF_FFFF :
                                 (f == 0 && j == 1) ? 32'h8000_0000 : $urandom);
        tx_eager = 1'b0;

        // every frame in use but the ramp never closes: frame 0 is the only read
        set_regs(13'h1FFF, 16'hFFFF, 32'd0);
        send(psp_pkg::OP_WRITE, 0, 0, frame0[0], 1'b0);
        send(psp_pkg::OP_START, 0, 0, 0, 1'b0);
        full_tick(1'b0);
        full_tick(1'b1);

        // zero budget ends the ramp at once; a single frame finishes next tick
        set_regs(13'd1, 16'd0, 32'd43);
        send(psp_pkg::OP_WRITE, 0, 0, frame0[0], 1'b0);
        send(psp_pkg::OP_START, 0, 0, 0, 1'b0);
        full_tick(1'b0);
        full_tick(1'b0);
        full_tick(1'b0);

        // huge threshold, yet random postures lie far from frame 0, so the ramp goes on
        set_regs(13'd3, 16'd3000, 32'hFFFF_FFFF);
        send(psp_pkg::OP_WRITE, 0, 0, frame0[0], 1'b0);
        send(psp_pkg::OP_START, 0, 0, 0, 1'b0);
        repeat (5) full_tick(1'b0);

        // shrink the frame count while still ramping
        set_regs(13'd2, 16'd1, 32'd0);
        full_tick(1'b0);

        // --- random phases ---
        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 3))
                0: thr = 32'd0;
                1: thr = 32'd43;
                2: thr = $urandom;
                default: thr = 32'hFFFF_FFFF;
            endcase
            set_regs(($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, LOADED)),
                     ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6)),
                     thr);
            rx_eager = ($urandom_range(0, 3) == 0);
            tx_eager = ($urandom_range(0, 3) == 0);
            if (phase_no == 3) begin
                rx_eager     = 1'b0;
                tx_eager     = 1'b1;
                rx_long_hold = 1'b1;
            end
            if ($urandom_range(0, 2) == 0)
                write_traj($urandom_range(0, LOADED - 1), $urandom_range(0, NJ - 1), $urandom);
            if ($urandom_range(0, 4) == 0)
                write_traj($urandom_range(LOADED, 4095), $urandom_range(0, NJ - 1), $urandom);
            if ($urandom_range(0, 3) != 0)
                send(psp_pkg::OP_WRITE, 0, 0, frame0[0], 1'b0);
            send(psp_pkg::OP_START, $urandom, $urandom, $urandom, 1'b0);
            nticks = $urandom_range(1, 8);
            for (int t = 0; t < nticks; t++) begin
                if ($urandom_range(0, 4) == 0) noise();
                full_tick($urandom_range(0, 2) == 0);
            end
            phase_no++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
